// ===== hw/rtl/wmec_pkg.sv =====
// Shared types and constants for the sliding window event counter.
// No dependencies; imported by every module of the block.
`default_nettype none

package wmec_pkg;

   localparam int unsigned DEFAULT_WINDOW_DEPTH = 1024;
   localparam int unsigned DEFAULT_TIME_BITS    = 32;
   localparam int unsigned QUEUE_DEPTH          = 2;
   localparam logic [31:0] WINDOW_LENGTH_RESET  = 32'd60;

   typedef struct packed {
      logic [31:0] event_time;
      logic        end_of_run;
   } req_type;

   typedef struct packed {
      logic [10:0] window_count;
      logic [10:0] best_count;
      logic [31:0] best_first_time;
      logic [31:0] best_last_time;
      logic        order_error;
      logic        window_full;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/wmec_front.sv =====
// Front end: takes request beats, flags out-of-order times, tracks run state.
// Depends on wmec_pkg; feeds wmec_queue.
`default_nettype none

module wmec_front #(
   parameter int unsigned TIME_BITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire wmec_pkg::req_type  req_data,
   input  wire logic               q_full,
   output logic                    q_push,
   output logic [TIME_BITS+1:0]    q_entry
);
   import wmec_pkg::*;

   logic [TIME_BITS-1:0] prev_time_ff, prev_time_in;
   logic                 seen_ff, seen_in;
   logic [TIME_BITS-1:0] req_time;
   logic                 order_err;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign req_time  = TIME_BITS'(req_data.event_time);
   assign order_err = seen_ff && (req_time < prev_time_ff);
   assign q_entry   = {req_time, req_data.end_of_run, order_err};

   always_comb begin
      prev_time_in = prev_time_ff;
      seen_in      = seen_ff;
      if (q_push) begin
         if (!order_err) begin
            prev_time_in = req_time;
            seen_in      = 1'b1;
         end
         if (req_data.end_of_run) begin
            prev_time_in = '0;
            seen_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         seen_ff      <= 1'b0;
      end else begin
         prev_time_ff <= prev_time_in;
         seen_ff      <= seen_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/wmec_queue.sv =====
// Short queue between front end and engine.
// Depends on wmec_pkg for its depth.
`default_nettype none

module wmec_queue #(
   parameter int unsigned WIDTH = 34
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  valid,
   output logic [WIDTH-1:0]      head_data
);
   import wmec_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid     = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/wmec_back.sv =====
// Engine: timestamp store, eviction, push, best-window tracking, result register.
// Depends on wmec_pkg; takes entries from wmec_queue.
`default_nettype none

module wmec_back #(
   parameter int unsigned WINDOW_DEPTH = 1024,
   parameter int unsigned TIME_BITS    = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [31:0]        window_length,
   input  wire logic               q_valid,
   input  wire logic [TIME_BITS+1:0] q_entry,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output wmec_pkg::rsp_type       rsp_data
);
   import wmec_pkg::*;

   localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
   localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);
   localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(WINDOW_DEPTH);

   logic [TIME_BITS-1:0] store_mem [WINDOW_DEPTH];
   logic [TIME_BITS-1:0] head_time_ff;

   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     occ_ff, occ_in;
   logic [CNT_W-1:0]     best_ff, best_in;
   logic [TIME_BITS-1:0] best_start_ff, best_start_in;
   logic [TIME_BITS-1:0] best_end_ff, best_end_in;
   logic                 full_ff, full_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [TIME_BITS-1:0] item_time;
   logic                 item_last, item_err;
   logic [TIME_BITS-1:0] age;
   logic                 evict_hit, out_free;
   logic [IDX_W-1:0]     head_inc, tail_idx;
   logic [CNT_W:0]       tail_sum;
   logic [CNT_W-1:0]     occ_inc;
   logic                 wr_en;
   logic [IDX_W-1:0]     rd_addr;

   assign item_time = q_entry[TIME_BITS+1:2];
   assign item_last = q_entry[1];
   assign item_err  = q_entry[0];
   assign age       = item_time - head_time_ff;
   assign evict_hit = (occ_ff != '0) && (CMP_W'(age) >= CMP_W'(window_length));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign head_inc  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_sum  = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(occ_ff);
   assign tail_idx  = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                              : IDX_W'(tail_sum);
   assign occ_inc   = occ_ff + 1'b1;
   assign rd_addr   = head_in;

   always_comb begin
      head_in       = head_ff;
      occ_in        = occ_ff;
      best_in       = best_ff;
      best_start_in = best_start_ff;
      best_end_in   = best_end_ff;
      full_in       = full_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      priority if (!q_valid) begin
      end else if (item_err) begin
         if (out_free) begin
            q_pop                       = 1'b1;
            rsp_valid_in                = 1'b1;
            rsp_data_in.window_count    = 11'(occ_ff);
            rsp_data_in.best_count      = 11'(best_ff);
            rsp_data_in.best_first_time = 32'(best_start_ff);
            rsp_data_in.best_last_time  = 32'(best_end_ff);
            rsp_data_in.order_error     = 1'b1;
            rsp_data_in.window_full     = 1'b0;
         end
      end else if (evict_hit) begin
         head_in = head_inc;
         occ_in  = occ_ff - 1'b1;
      end else if (occ_ff == DEPTH_CNT) begin
         head_in = head_inc;
         occ_in  = occ_ff - 1'b1;
         full_in = 1'b1;
      end else if (out_free) begin
         q_pop   = 1'b1;
         wr_en   = 1'b1;
         occ_in  = occ_inc;
         full_in = 1'b0;
         if (occ_inc > best_ff) begin
            best_in       = occ_inc;
            best_start_in = (occ_ff == '0) ? item_time : head_time_ff;
            best_end_in   = item_time;
         end
         rsp_valid_in                = 1'b1;
         rsp_data_in.window_count    = 11'(occ_inc);
         rsp_data_in.best_count      = 11'(best_in);
         rsp_data_in.best_first_time = 32'(best_start_in);
         rsp_data_in.best_last_time  = 32'(best_end_in);
         rsp_data_in.order_error     = 1'b0;
         rsp_data_in.window_full     = full_ff;
      end else begin
      end
      if (q_pop && item_last) begin
         head_in       = '0;
         occ_in        = '0;
         best_in       = '0;
         best_start_in = '0;
         best_end_in   = '0;
         full_in       = 1'b0;
      end
   end

   // store write, and head read with bypass of a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[tail_idx] <= item_time;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (tail_idx == rd_addr)) begin
         head_time_ff <= item_time;
      end else begin
         head_time_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         occ_ff        <= '0;
         best_ff       <= '0;
         best_start_ff <= '0;
         best_end_ff   <= '0;
         full_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         occ_ff        <= occ_in;
         best_ff       <= best_in;
         best_start_ff <= best_start_in;
         best_end_ff   <= best_end_in;
         full_ff       <= full_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= DEPTH_CNT)
      else $error("occupancy beyond store depth");

   a_occ_le_best: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= best_ff)
      else $error("window count above best count");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (occ_ff == DEPTH_CNT - 1'b1))
      else $error("full flag without a dropped entry");

   a_evict_step: assert property (@(posedge clock) disable iff (reset)
      (q_valid && !item_err && evict_hit) |=> (occ_ff == $past(occ_ff) - 1'b1))
      else $error("eviction did not shrink the window");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/window_max_event_count_top.sv =====
// Top level of the sliding window maximum event counter.
// Depends on wmec_pkg, wmec_front, wmec_queue and wmec_back.
//
//   channel | ports                        | direction | handshake
//   --------+------------------------------+-----------+--------------------------
//   request | req_valid req_stall req_data | in        | beat when valid & !stall
//   result  | rsp_valid rsp_stall rsp_data | out       | beat when valid & !stall
//   csr     | csr_write_enable/write_data  | in        | write when enable high
//
// The engine handles one event at a time: it evicts expired timestamps one by one
// through the store's single read port, drops the oldest entry when the store is full,
// and then stores an in-order event; the queue holds further requests meanwhile.
// Reset is synchronous; the timestamp store is not cleared, only its pointers.
// A two-beat queue lets requests land while the engine waits on a stalled result.
`default_nettype none

module window_max_event_count_top #(
   parameter int unsigned WINDOW_DEPTH = wmec_pkg::DEFAULT_WINDOW_DEPTH,
   parameter int unsigned TIME_BITS    = wmec_pkg::DEFAULT_TIME_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire wmec_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output wmec_pkg::rsp_type       rsp_data,
   input  wire logic               csr_write_enable,
   input  wire logic [31:0]        csr_write_data
);
   import wmec_pkg::*;

   logic [31:0]          window_length_ff;
   logic                 q_push, q_full, q_pop, q_valid;
   logic [TIME_BITS+1:0] q_in_entry, q_out_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_RESET;
      end else if (csr_write_enable) begin
         window_length_ff <= csr_write_data;
      end
   end

   wmec_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_in_entry)
   );

   wmec_queue #(
      .WIDTH (TIME_BITS + 2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_entry),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head_data (q_out_entry)
   );

   wmec_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .TIME_BITS    (TIME_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .window_length (window_length_ff),
      .q_valid       (q_valid),
      .q_entry       (q_out_entry),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for window_max_event_count_top: a queue-fed driver, a clocked
// monitor and a built-in prediction of the sliding window counts and best window.
// Depends on wmec_pkg and the RTL of the block; needs no files or arguments.
module tb_top;
   import wmec_pkg::*;

   localparam int STORE_DEPTH = DEFAULT_WINDOW_DEPTH;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;

   // prediction state
   logic [31:0] span_now = WINDOW_LENGTH_RESET;
   logic [31:0] held_times[$];
   logic [10:0] top_count;
   logic [31:0] top_first;
   logic [31:0] top_last;
   logic [31:0] last_time;
   logic        seen;

   req_type     beats_to_send[$];
   rsp_type     results_due[$];
   rsp_type     want;
   int          mismatches = 0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   int          holds_asked = 0;
   int          holds_served = 0;
   logic        tx_steady = 1'b0;
   logic        rx_steady = 1'b0;
   int          k;

   window_max_event_count_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
      if (mismatches < 40)
         $display("mismatch %s: got %h want %h", what, got, exp_val);
      mismatches++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic void forget_run();
      held_times.delete();
      top_count = '0;
      top_first = '0;
      top_last  = '0;
      last_time = '0;
      seen      = 1'b0;
   endfunction

   function automatic rsp_type count_window(req_type beat);
      rsp_type r;
      r = '0;
      if (seen && beat.event_time < last_time) begin
         r.order_error = 1'b1;
      end else begin
         while (held_times.size() > 0 && (beat.event_time - held_times[0]) >= span_now)
            held_times.delete(0);
         if (held_times.size() >= STORE_DEPTH) begin
            held_times.delete(0);
            r.window_full = 1'b1;
         end
         held_times.push_back(beat.event_time);
         if (held_times.size() > top_count) begin
            top_count = 11'(held_times.size());
            top_first = held_times[0];
            top_last  = beat.event_time;
         end
         last_time = beat.event_time;
         seen      = 1'b1;
      end
      r.window_count    = 11'(held_times.size());
      r.best_count      = top_count;
      r.best_first_time = top_first;
      r.best_last_time  = top_last;
      if (beat.end_of_run)
         forget_run();
      return r;
   endfunction

   // driver: a beat stays put while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         forget_run();
      end else begin
         if (req_valid && !req_stall)
            results_due.push_back(count_window(req_data));
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0 || beats_to_send.size() == 0) begin
               if (send_gap > 0)
                  send_gap--;
               req_valid <= 1'b0;
            end else begin
               req_data  <= beats_to_send.pop_front();
               req_valid <= 1'b1;
               send_gap = tx_steady ? 0 : pick_gap();
            end
         end
      end
   end

   // monitor and result-side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_data.window_count), '0);
            end else begin
               want = results_due.pop_front();
               if (rsp_data.window_count !== want.window_count)
                  report_mismatch("window_count", 32'(rsp_data.window_count),
                                  32'(want.window_count));
               if (rsp_data.best_count !== want.best_count)
                  report_mismatch("best_count", 32'(rsp_data.best_count),
                                  32'(want.best_count));
               if (rsp_data.best_first_time !== want.best_first_time)
                  report_mismatch("best_first_time", rsp_data.best_first_time,
                                  want.best_first_time);
               if (rsp_data.best_last_time !== want.best_last_time)
                  report_mismatch("best_last_time", rsp_data.best_last_time,
                                  want.best_last_time);
               if (rsp_data.order_error !== want.order_error)
                  report_mismatch("order_error", 32'(rsp_data.order_error),
                                  32'(want.order_error));
               if (rsp_data.window_full !== want.window_full)
                  report_mismatch("window_full", 32'(rsp_data.window_full),
                                  32'(want.window_full));
            end
         end
         if (holds_served < holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = rx_steady ? 0 : pick_gap();
         end
      end
   end

   task automatic offer(logic [31:0] t, logic last);
      req_type b;
      b.event_time = t;
      b.end_of_run = last;
      beats_to_send.push_back(b);
   endtask

   task automatic settle();
      while (beats_to_send.size() != 0 || req_valid || results_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_span(logic [31:0] v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      span_now = v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [31:0] fresh_base();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1000);
         1: return $urandom;
         2: return 32'hFFFF_FFFF - $urandom_range(0, 5000);
         default: return $urandom >> 4;
      endcase
   endfunction

   // nondecreasing runs with random content, some backwards beats as noise
   task automatic random_runs(int count);
      logic [31:0] t;
      logic [32:0] step;
      logic [32:0] sum;
      logic        last;
      int          n;
      t = fresh_base();
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 8 && t != 0) begin
            last = ($urandom_range(0, 4) == 0);
            offer($urandom_range(0, t - 1), last);
            if (last)
               t = fresh_base();
         end else begin
            case ($urandom_range(0, 9))
               0, 1:    step = '0;
               2, 3, 4: step = 33'($urandom_range(0, 3));
               5, 6:    step = 33'($urandom_range(0, span_now >> 2));
               7, 8: begin
                  step = {1'b0, span_now} + 33'($urandom_range(0, 2));
                  if (step != 0)
                     step = step - 1;
               end
               default: step = 33'($urandom >> $urandom_range(0, 31));
            endcase
            sum = {1'b0, t} + step;
            t = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            last = ($urandom_range(0, 29) == 0);
            offer(t, last);
            if (last)
               t = fresh_base();
         end
      end
      offer(t, 1'b1);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset span: lone event, ties, eviction at the exact span, backwards beats
      offer(32'd0, 1'b1);
      offer(32'd10, 1'b0);
      offer(32'd10, 1'b0);
      offer(32'd69, 1'b0);
      offer(32'd70, 1'b0);
      offer(32'd129, 1'b0);
      offer(32'd5, 1'b0);
      offer(32'd130, 1'b0);
      offer(32'd131, 1'b0);
      offer(32'd150, 1'b0);
      offer(32'd3, 1'b1);
      offer(32'hFFFF_FFFF, 1'b0);
      offer(32'hFFFF_FFFF, 1'b0);
      offer(32'hFFFF_FFBE, 1'b0);
      offer(32'hFFFF_FFFF, 1'b1);
      offer(32'h8000_0000, 1'b0);
      offer(32'h7FFF_FFFF, 1'b0);
      offer(32'hAAAA_AAAA, 1'b0);
      offer(32'h5555_5555, 1'b1);
      offer(32'h5555_5555, 1'b1);
      settle();

      set_span(32'd0);
      offer(32'd7, 1'b0);
      offer(32'd7, 1'b0);
      offer(32'd8, 1'b1);
      settle();

      set_span(32'd1);
      offer(32'd7, 1'b0);
      offer(32'd7, 1'b0);
      offer(32'd7, 1'b0);
      offer(32'd8, 1'b1);
      settle();

      // widest span: overfill the store, then the full-range distance
      set_span(32'hFFFF_FFFF);
      begin
         logic [31:0] t;
         t = 32'h100;
         for (k = 0; k < STORE_DEPTH + 6; k++) begin
            t = t + $urandom_range(0, 2);
            offer(t, k == STORE_DEPTH + 5);
         end
      end
      offer(32'd0, 1'b0);
      offer(32'hFFFF_FFFF, 1'b1);
      settle();

      for (k = 0; k < 8; k++) begin
         tx_steady = (k == 1) || (k == 5);
         rx_steady = (k == 3) || (k == 5);
         case (k)
            0: set_span(WINDOW_LENGTH_RESET);
            1: set_span(32'd1);
            2: set_span($urandom_range(2, 200));
            3: set_span(32'hFFFF_FFFF);
            4: set_span($urandom_range(200, 20000));
            5: set_span($urandom);
            6: set_span(32'd0);
            default: set_span(32'h8000_0000);
         endcase
         if (k == 2) begin
            random_runs(62);
            holds_asked++;
         end else if (k == 4) begin
            random_runs(31);
            settle();
            random_runs(31);
         end else begin
            random_runs(62);
         end
         settle();
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;

      for (k = 0; k < 100000 && results_due.size() != 0; k++)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (results_due.size() != 0)
         report_mismatch("results never seen", 32'(results_due.size()), '0);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
